/* rtl/mchw_pkg.sv */
// Shared types and constants for the multi-channel hang watchdog.
// Used by the front queue, the back sequencer and the top level.
package mchw_pkg;

  localparam int CHANNELS_DEF    = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int NAP_THR_W       = 16;
  localparam int MIN_TMO_W       = 17;
  localparam int CFG_DATA_W      = 17;
  localparam int TIME_W          = 32;
  localparam int CH_W            = 4;
  localparam logic [NAP_THR_W-1:0] NAP_THR_RESET = 16'd1000;
  localparam logic [MIN_TMO_W-1:0] MIN_TMO_RESET = 17'd2000;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_KICK       = 2'd1,
    OP_UNREGISTER = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_HANG = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RAISED    = 2'd1,
    ST_NOT_ARMED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_WALK = 2'd1,
    B_END  = 2'd2
  } bstate_t;

  typedef enum logic {
    CFG_NAP_THRESHOLD = 1'b0,
    CFG_MIN_TIMEOUT   = 1'b1
  } cfg_idx_t;

  // One queued command, already classified by the front.
  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] now;
    logic              ch_bad;
  } cmd_t;

  typedef struct packed {
    logic [NAP_THR_W-1:0] nap_threshold;
    logic [MIN_TMO_W-1:0] min_timeout;
  } cfg_t;

  typedef struct packed {
    kind_t           kind;
    logic [CH_W-1:0] ch;
    status_t         status;
    logic            nap;
    logic            last;
  } res_t;

endpackage

/* rtl/multi_channel_hang_watchdog_unit.sv */
// Top level of the multi-channel hang watchdog: configuration registers,
// front queue and back sequencer. Depends on mchw_pkg, mchw_front, mchw_back.
//
// Usage: commands arrive on the in_ channel (valid/stall). Register, kick and
// unregister each give one acknowledge on the out_ channel; a tick gives one
// hang report per silent armed channel, none after a nap reset, in ascending
// order, then one end of tick. out_last marks the final result of each item.
// Flow: an item is written into a two-entry queue; when the back is idle and
// the output register is free, a command is popped and its result loaded there.
// A tick is run as a walk that reads one channel per cycle from the timeout
// and last-signal memories, pausing while a hang report waits on a stalled
// output; the queue is not popped again until the end of tick is loaded.
// When out_stall is high the result holds in the output register and the back
// waits to load another result; the queue keeps taking items until it is full,
// then in_stall rises. Configuration is written through cfg_we/cfg_index/
// cfg_wdata with no wait. Reset clears the armed flags, the previous tick time,
// the queue and restores the default thresholds; the stores need no clearing.
module multi_channel_hang_watchdog_unit #(
  parameter int CHANNELS = mchw_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mchw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [mchw_pkg::CH_W-1:0]       in_channel,
  input  logic [mchw_pkg::TIME_W-1:0]     in_timeout_ms,
  input  logic [mchw_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [mchw_pkg::CH_W-1:0]       out_hung_channel,
  output logic [1:0]                      out_status,
  output logic                            out_nap_reset,
  output logic                            out_last
);
  import mchw_pkg::*;

  cfg_t cfg_r;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nap_threshold <= NAP_THR_RESET;
      cfg_r.min_timeout   <= MIN_TMO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NAP_THRESHOLD: cfg_r.nap_threshold <= cfg_wdata[NAP_THR_W-1:0];
        CFG_MIN_TIMEOUT:   cfg_r.min_timeout   <= cfg_wdata[MIN_TMO_W-1:0];
        default: ;
      endcase
    end
  end

  mchw_front #(.CHANNELS(CHANNELS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_channel    (in_channel),
    .in_timeout_ms (in_timeout_ms),
    .in_now_ms     (in_now_ms),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  mchw_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_hung_channel = res.ch;
  assign out_status       = res.status;
  assign out_nap_reset    = res.nap;
  assign out_last         = res.last;

endmodule

/* rtl/mchw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mchw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/mchw_front.sv */
// Front of the watchdog: accepts items, flags out-of-range channels and
// holds them in a short queue for the back. Depends on mchw_pkg.
module mchw_front #(
  parameter int CHANNELS = mchw_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [mchw_pkg::CH_W-1:0]    in_channel,
  input  logic [mchw_pkg::TIME_W-1:0]  in_timeout_ms,
  input  logic [mchw_pkg::TIME_W-1:0]  in_now_ms,
  output logic                         q_valid,
  output mchw_pkg::cmd_t               q_cmd,
  input  logic                         q_pop
);
  import mchw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.op     = op_t'(in_opcode);
    cmd_in.ch     = in_channel;
    cmd_in.tmo    = in_timeout_ms;
    cmd_in.now    = in_now_ms;
    cmd_in.ch_bad = 32'(in_channel) >= CHANNELS;
  end

  assign in_stall = count_r == CNT_W'(QUEUE_DEPTH);
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != '0;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/mchw_back.sv */
// Back of the watchdog: executes queued commands, holds the channel state
// and walks all channels on a tick. Depends on mchw_pkg and mchw_ram.
module mchw_back #(
  parameter int CHANNELS = mchw_pkg::CHANNELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mchw_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  mchw_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mchw_pkg::res_t out_res
);
  import mchw_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  bstate_t             state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                nap_r, nap_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   prev_tick_r, prev_tick_nxt;
  logic [CHANNELS-1:0] armed_r, armed_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r;

  logic                load;
  res_t                res;
  logic                out_free;
  logic [IDX_W-1:0]    ch_idx;
  logic                tmo_low;
  logic                nap_hit;
  logic [TIME_W-1:0]   walk_gap;
  logic                walk_armed;
  logic                walk_hung;
  logic                idx_last;
  logic                go;

  logic                tmo_we;
  logic [TIME_W-1:0]   tmo_wdata;
  logic [TIME_W-1:0]   tmo_rd;
  logic                ls_we;
  logic [IDX_W-1:0]    ls_waddr;
  logic [TIME_W-1:0]   ls_wdata;
  logic [TIME_W-1:0]   ls_rd;

  // Reads follow the next walk index so the data for idx_r is ready in WALK.
  mchw_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_tmo_ram (
    .clk   (clk),
    .we    (tmo_we),
    .waddr (ch_idx),
    .wdata (tmo_wdata),
    .raddr (idx_nxt),
    .rdata (tmo_rd)
  );

  mchw_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_last_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (idx_nxt),
    .rdata (ls_rd)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign ch_idx     = IDX_W'(q_cmd.ch);
  assign tmo_low    = q_cmd.tmo <= 32'(cfg.min_timeout);
  assign nap_hit    = (q_cmd.now - prev_tick_r) >= 32'(cfg.nap_threshold);
  assign walk_gap   = now_r - ls_rd;
  assign walk_armed = armed_r[idx_r];
  // After a nap reset every armed timer reads as just refreshed.
  assign walk_hung  = !nap_r && walk_armed && (walk_gap > tmo_rd);
  assign idx_last   = idx_r == IDX_W'(CHANNELS - 1);
  assign go         = !walk_hung || out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && q_cmd.op == OP_TICK) begin
          state_nxt = B_WALK;
        end
      end
      B_WALK: begin
        if (go && idx_last) begin
          state_nxt = B_END;
        end
      end
      B_END: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    load          = 1'b0;
    res           = '0;
    armed_nxt     = armed_r;
    idx_nxt       = idx_r;
    nap_nxt       = nap_r;
    now_nxt       = now_r;
    prev_tick_nxt = prev_tick_r;
    tmo_we        = 1'b0;
    tmo_wdata     = tmo_low ? 32'(cfg.min_timeout) : q_cmd.tmo;
    ls_we         = 1'b0;
    ls_waddr      = ch_idx;
    ls_wdata      = q_cmd.now;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && q_cmd.op == OP_TICK) begin
          q_pop         = 1'b1;
          idx_nxt       = '0;
          nap_nxt       = nap_hit;
          now_nxt       = q_cmd.now;
          prev_tick_nxt = q_cmd.now;
        end else if (q_valid && out_free) begin
          q_pop      = 1'b1;
          load       = 1'b1;
          res.kind   = KIND_ACK;
          res.ch     = q_cmd.ch;
          res.last   = 1'b1;
          res.status = ST_NOT_ARMED;
          if (!q_cmd.ch_bad) begin
            unique case (q_cmd.op)
              OP_REGISTER: begin
                armed_nxt[ch_idx] = 1'b1;
                tmo_we            = 1'b1;
                ls_we             = 1'b1;
                res.status        = tmo_low ? ST_RAISED : ST_OK;
              end
              OP_KICK: begin
                if (armed_r[ch_idx]) begin
                  ls_we      = 1'b1;
                  res.status = ST_OK;
                end
              end
              OP_UNREGISTER: begin
                if (armed_r[ch_idx]) begin
                  armed_nxt[ch_idx] = 1'b0;
                  res.status        = ST_OK;
                end
              end
              default: ;
            endcase
          end
        end
      end
      B_WALK: begin
        ls_waddr = idx_r;
        ls_wdata = now_r;
        if (go) begin
          ls_we = walk_armed && (nap_r || walk_hung);
          if (walk_hung) begin
            load     = 1'b1;
            res.kind = KIND_HANG;
            res.ch   = CH_W'(idx_r);
          end
          if (!idx_last) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      B_END: begin
        if (out_free) begin
          load     = 1'b1;
          res.kind = KIND_END;
          res.nap  = nap_r;
          res.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      nap_r       <= 1'b0;
      prev_tick_r <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      nap_r       <= nap_nxt;
      prev_tick_r <= prev_tick_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The queue is drained only between commands, never during a walk.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == B_IDLE)
    else $error("queue popped outside idle");

  // End of tick is reached only through the channel walk.
  a_end_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_END) |-> ($past(state_r) == B_WALK || $past(state_r) == B_END))
    else $error("end of tick without a walk");

  // A hang report is never the final result of a tick.
  a_hang_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == KIND_HANG) |-> !out_res_r.last)
    else $error("hang report flagged last");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> !$past(load))
    else $error("result overwrote a stalled one");

endmodule
